### hdl/weighted_edit_distance_core_macros.svh
// ----------------------------------------------------------------------------
// Weighted edit distance core: assertion macros
// Implication checks used by the core; they compile to nothing under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_EDIT_DISTANCE_CORE_MACROS_SVH
`define WEIGHTED_EDIT_DISTANCE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define WED_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle implication failed");
// Next-cycle implication.
`define WED_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");
`else
`define WED_ASSERT_IMP(label, clk, rst_n, a, b)
`define WED_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

### hdl/wed_pkg.sv
// ----------------------------------------------------------------------------
// Weighted edit distance package
// Sizes, codes, control structs and saturating arithmetic shared by the core.
// ----------------------------------------------------------------------------
package wed_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int ADDR_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	localparam int CELL_W = 32;
	localparam int WGT_W = 16;
	localparam int PLEN_W = 7;
	localparam int PADDR_W = 5;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_TEXT = 2'd1;
	localparam logic [1:0] FUNC_END = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_SUB = 3'd0;
	localparam logic [2:0] REG_DEL = 3'd1;
	localparam logic [2:0] REG_INS = 3'd2;
	localparam logic [2:0] REG_LEN = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	typedef struct packed {
		logic [WGT_W-1:0] sub;
		logic [WGT_W-1:0] del;
		logic [WGT_W-1:0] ins;
		logic [LEN_W-1:0] len;
		logic search;
	} wed_cfg_t;

	typedef struct packed {
		logic take;
		logic pat_we;
		logic open_init;
		logic open_step;
		logic open_done;
		logic walk_start;
		logic walk_step;
		logic walk_end;
		logic res_load;
	} wed_cmd_t;

	typedef struct packed {
		logic open_last;
		logic walk_last;
		logic len_zero;
	} wed_stat_t;

	function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
		input logic [WGT_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} + {{(CELL_W + 1 - WGT_W){1'b0}}, b};
		return s[CELL_W] ? {CELL_W{1'b1}} : s[CELL_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] min_cell(input logic [CELL_W-1:0] a,
		input logic [CELL_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

### hdl/wed_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one pattern or text item.
// ----------------------------------------------------------------------------
interface wed_in_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [5:0] position;
	logic [7:0] char_value;
	logic last;

	modport source (output valid, output func, output position, output char_value,
		output last, input ready);
	modport sink (input valid, input func, input position, input char_value,
		input last, output ready);
endinterface

### hdl/wed_out_if.sv
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying one distance result.
// ----------------------------------------------------------------------------
interface wed_out_if;
	logic valid;
	logic ready;
	logic [31:0] distance;

	modport source (output valid, output distance, input ready);
	modport sink (input valid, input distance, output ready);
endinterface

### hdl/weighted_edit_distance_core.sv
// ----------------------------------------------------------------------------
// Weighted edit distance core
// Weighted edit distance between a stored pattern and a streamed text string.
// ----------------------------------------------------------------------------
// A pattern of up to 64 bytes is loaded with load items (one byte per item,
// at its position), and text bytes then stream in as text items, one per
// item. Each text byte updates one column of the dynamic-programming table,
// walking the pattern cells one per clock through a single cell-update unit
// that reads the column memory and writes it back. A text item on an open
// string therefore passes through accept, column start, the cell walk and
// column end, then result delivery when it closes the string. The pattern
// length used here is capped at 64. The first text or end item of a string
// first loads the border column into memory, one cell per clock. Weights
// are unsigned 8.8 fixed point and every sum saturates at the 32-bit
// maximum. In match mode the result is the bottom cell of the final column;
// in search mode it is the least bottom cell seen over the string, started
// at the lesser of pattern_length * 256 and the bottom border cell. A text
// item with last set, or an end item, delivers the result and closes the
// string; an end item with no open string reports the empty-text result. A
// write to any of the five registers abandons an open string. The user must
// write registers only while the core is idle; the core does not enforce
// it. The result sits in an output register, so the next item is taken
// while a result still waits to be collected; a second result then holds
// the core until the first one has been taken.
// ----------------------------------------------------------------------------
`include "weighted_edit_distance_core_macros.svh"

module weighted_edit_distance_core
	import wed_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	wed_in_if.sink item_in,
	wed_out_if.source result
);
	logic [WGT_W-1:0] sub_q;
	logic [WGT_W-1:0] del_q;
	logic [WGT_W-1:0] ins_q;
	logic [PLEN_W-1:0] plen_q;
	logic search_q;

	logic [2:0] reg_idx;
	logic cfg_wr;
	logic cfg_clear;
	logic [LEN_W-1:0] len_used;

	wed_cfg_t cfg;
	wed_cmd_t cmd;
	wed_stat_t st;

	// The register file takes a write in the access phase of the transfer.
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite;

	// Only writes that hit a real register abandon an open string.
	always_comb begin
		cfg_clear = 1'b0;
		if (cfg_wr) begin
			unique case (reg_idx) inside
				REG_SUB, REG_DEL, REG_INS, REG_LEN, REG_MODE: cfg_clear = 1'b1;
				default: cfg_clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= WGT_W'(256);
			del_q <= WGT_W'(256);
			ins_q <= WGT_W'(256);
			plen_q <= '0;
			search_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SUB: sub_q <= pwdata[WGT_W-1:0];
				REG_DEL: del_q <= pwdata[WGT_W-1:0];
				REG_INS: ins_q <= pwdata[WGT_W-1:0];
				REG_LEN: plen_q <= pwdata[PLEN_W-1:0];
				REG_MODE: search_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SUB: prdata = {16'd0, sub_q};
			REG_DEL: prdata = {16'd0, del_q};
			REG_INS: prdata = {16'd0, ins_q};
			REG_LEN: prdata = {25'd0, plen_q};
			REG_MODE: prdata = {31'd0, search_q};
			default: prdata = '0;
		endcase
	end

	// A length beyond the pattern store acts as a full-length pattern.
	assign len_used = (int'(plen_q) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) :
		LEN_W'(plen_q);

	assign cfg.sub = sub_q;
	assign cfg.del = del_q;
	assign cfg.ins = ins_q;
	assign cfg.len = len_used;
	assign cfg.search = search_q;

	wed_controller u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_clear(cfg_clear),
		.in_valid(item_in.valid),
		.in_func(item_in.func),
		.in_last(item_in.last),
		.in_ready(item_in.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.st(st),
		.cmd(cmd)
	);

	wed_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.position(item_in.position),
		.char_value(item_in.char_value),
		.st(st),
		.distance(result.distance)
	);

	// A new result never lands on one that is still waiting.
	`WED_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.res_load, !result.valid || result.ready)
	// A loaded result is offered on the next cycle.
	`WED_ASSERT_NXT(a_res_shown, clk, arst_n, cmd.res_load, result.valid)
	// The cell walk never runs over an empty pattern.
	`WED_ASSERT_IMP(a_walk_len, clk, arst_n, cmd.walk_step, !st.len_zero)
	// Loading the border column keeps the input channel closed.
	`WED_ASSERT_NXT(a_open_busy, clk, arst_n, cmd.open_init, !item_in.ready)

endmodule

### hdl/wed_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/wed_datapath.sv
// ----------------------------------------------------------------------------
// Weighted edit distance datapath
// Pattern and column memories, the cell update and the result registers.
// ----------------------------------------------------------------------------
module wed_datapath
	import wed_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input wed_cfg_t cfg,
	input wed_cmd_t cmd,
	input logic [5:0] position,
	input logic [7:0] char_value,
	output wed_stat_t st,
	output logic [CELL_W-1:0] distance
);
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] cnt_nx;
	logic [CELL_W-1:0] acc_q;
	logic [CELL_W-1:0] col0_q;
	logic [CELL_W-1:0] top_q;
	logic [CELL_W-1:0] cell_q;
	logic [CELL_W-1:0] rmin_q;
	logic [CELL_W-1:0] dist_q;
	logic [7:0] char_q;

	logic [7:0] pat_rd;
	logic [CELL_W-1:0] col_rd;
	logic [ADDR_W-1:0] raddr;
	logic col_we;
	logic [CELL_W-1:0] col_wdata;
	logic pat_we;

	logic [CELL_W-1:0] col0_new;
	logic [CELL_W-1:0] diag_sum;
	logic [CELL_W-1:0] up_sum;
	logic [CELL_W-1:0] left_sum;
	logic [CELL_W-1:0] cell_new;
	logic [CELL_W-1:0] start_min;

	assign cnt_nx = cnt_q + LEN_W'(1);
	assign raddr = cmd.walk_start ? '0 : cnt_nx[ADDR_W-1:0];
	assign pat_we = cmd.pat_we && (int'(position) < PATTERN_MAX);
	assign col_we = cmd.open_step || cmd.walk_step;
	assign col_wdata = cmd.open_step ? acc_q : cell_new;

	wed_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pat_ram (
		.clk(clk),
		.we(pat_we),
		.waddr(ADDR_W'(position)),
		.wdata(char_value),
		.raddr(raddr),
		.rdata(pat_rd)
	);

	wed_ram #(.WIDTH(CELL_W), .DEPTH(PATTERN_MAX)) u_col_ram (
		.clk(clk),
		.we(col_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(col_wdata),
		.raddr(raddr),
		.rdata(col_rd)
	);

	// Cell i takes the least of diagonal, cell above and cell to the left.
	always_comb begin
		col0_new = cfg.search ? '0 : sat_add(col0_q, cfg.del);
		diag_sum = sat_add(top_q, (pat_rd == char_q) ? '0 : cfg.sub);
		up_sum = sat_add(cell_q, cfg.ins);
		left_sum = sat_add(col_rd, cfg.del);
		cell_new = min_cell(min_cell(diag_sum, up_sum), left_sum);
		start_min = {{(CELL_W - LEN_W - 8){1'b0}}, cfg.len, 8'd0};
	end

	assign st.open_last = (cnt_q == cfg.len);
	assign st.walk_last = (cnt_nx == cfg.len);
	assign st.len_zero = (cfg.len == '0);
	assign distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.open_init || cmd.walk_start) begin
			cnt_q <= '0;
		end else if (cmd.open_step || cmd.walk_step) begin
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= char_value;
		end
		if (cmd.open_init) begin
			acc_q <= {{(CELL_W - WGT_W){1'b0}}, cfg.del};
			cell_q <= '0;
		end
		if (cmd.open_step) begin
			acc_q <= sat_add(acc_q, cfg.del);
			cell_q <= acc_q;
		end
		if (cmd.open_done) begin
			rmin_q <= min_cell(cell_q, start_min);
			col0_q <= '0;
		end
		if (cmd.walk_start) begin
			top_q <= col0_q;
			col0_q <= col0_new;
			cell_q <= col0_new;
		end
		if (cmd.walk_step) begin
			top_q <= col_rd;
			cell_q <= cell_new;
		end
		if (cmd.walk_end) begin
			rmin_q <= min_cell(rmin_q, cell_q);
		end
		if (cmd.res_load) begin
			dist_q <= cfg.search ? rmin_q : cell_q;
		end
	end
endmodule

### hdl/wed_controller.sv
// ----------------------------------------------------------------------------
// Weighted edit distance controller
// Sequences border load, column walk and result delivery for each item.
// ----------------------------------------------------------------------------
module wed_controller
	import wed_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_clear,
	input logic in_valid,
	input logic [1:0] in_func,
	input logic in_last,
	output logic in_ready,
	input logic out_ready,
	output logic out_valid,
	input wed_stat_t st,
	output wed_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_OPEN,
		S_WSTART,
		S_WALK,
		S_WEND,
		S_DONE
	} state_t;

	state_t state_q;
	logic text_open_q;
	logic is_text_q;
	logic last_q;
	logic out_valid_q;
	logic accept;
	logic is_string_func;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign is_string_func = (in_func == FUNC_TEXT) || (in_func == FUNC_END);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.take = accept;
		cmd.pat_we = accept && (in_func == FUNC_LOAD);
		cmd.open_init = accept && is_string_func && !text_open_q;
		unique case (state_q)
			S_OPEN: begin
				cmd.open_step = !st.open_last;
				cmd.open_done = st.open_last;
			end
			S_WSTART: cmd.walk_start = 1'b1;
			S_WALK: cmd.walk_step = 1'b1;
			S_WEND: cmd.walk_end = 1'b1;
			S_DONE: cmd.res_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			text_open_q <= 1'b0;
			is_text_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_clear) begin
				text_open_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && is_string_func) begin
						is_text_q <= (in_func == FUNC_TEXT);
						last_q <= in_last;
						if (!text_open_q) begin
							state_q <= S_OPEN;
						end else if (in_func == FUNC_TEXT) begin
							state_q <= S_WSTART;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_OPEN: begin
					if (st.open_last) begin
						text_open_q <= 1'b1;
						state_q <= is_text_q ? S_WSTART : S_DONE;
					end
				end
				S_WSTART: state_q <= st.len_zero ? S_WEND : S_WALK;
				S_WALK: begin
					if (st.walk_last) begin
						state_q <= S_WEND;
					end
				end
				S_WEND: state_q <= last_q ? S_DONE : S_IDLE;
				S_DONE: begin
					if (cmd.res_load) begin
						out_valid_q <= 1'b1;
						text_open_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Weighted edit distance core testbench
// Streams pattern loads, text strings and stray items through the core under
// changing weights, lengths and modes. Valid and ready are throttled at
// random, and every distance that comes out is checked against a local
// predictor of the dynamic-programming column.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wed_pkg::*;

	// The function code that the core must ignore has no name in the package.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// A text item on a fresh string at full length takes the border load plus
	// the column walk, so this covers any work still in flight after the last
	// distance has been collected.
	localparam int SETTLE_CYCLES = 2 * PATTERN_MAX + 16;
	localparam int RANDOM_ITEMS = 650;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] position;
		logic [7:0] char_value;
		logic last;
	} engine_item_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	wed_in_if item_ch();
	wed_out_if result_ch();

	weighted_edit_distance_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_in(item_ch),
		.result(result_ch)
	);

	// Items waiting to be offered to the core, and distances that accepted
	// items have promised but the core has not yet delivered.
	engine_item_t pending_items[$];
	logic [CELL_W-1:0] expected_distances[$];

	// Predictor copy of the register file.
	logic [WGT_W-1:0] sub_weight;
	logic [WGT_W-1:0] del_weight;
	logic [WGT_W-1:0] ins_weight;
	logic [PLEN_W-1:0] length_reg;
	logic search_on;

	// Predictor copy of the core's working state.
	logic [7:0] pattern_bytes [PATTERN_MAX];
	logic [CELL_W-1:0] dp_column [PATTERN_MAX + 1];
	logic [CELL_W-1:0] diag_cell;
	logic [CELL_W-1:0] best_bottom;
	logic string_open;

	// Stimulus bookkeeping. The loaded mask keeps the generator from ever
	// walking a pattern entry that has not been written.
	logic [PATTERN_MAX-1:0] loaded_mask;
	int random_count;
	int sender_idle_pct;
	int stall_pct;
	int error_count = 0;
	engine_item_t next_item;
	logic [CELL_W-1:0] wanted_distance;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that hangs anywhere ends here.
	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Unsigned add that sticks at the top of the cell range.
	function automatic logic [CELL_W-1:0] capped_sum(input logic [CELL_W-1:0] a,
		input logic [WGT_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} + (CELL_W + 1)'(b);
		return s[CELL_W] ? '1 : s[CELL_W-1:0];
	endfunction

	// A length register above the pattern capacity acts as full capacity.
	function automatic int cells_in_use();
		return (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
	endfunction

	// The first text or end item of a string loads the border column from the
	// registers as they are now, and seeds the search minimum with the
	// smaller of length * 256 and the bottom border cell.
	function automatic void open_text();
		int n;
		int i;
		logic [CELL_W-1:0] floor_value;
		n = cells_in_use();
		for (i = 0; i <= n; i++)
			dp_column[i] = CELL_W'(i) * CELL_W'(del_weight);
		diag_cell = '0;
		floor_value = CELL_W'(n) * CELL_W'(256);
		best_bottom = (dp_column[n] < floor_value) ? dp_column[n] : floor_value;
		string_open = 1'b1;
	endfunction

	// One text byte moves the column one step along the text. The top cell
	// grows by the deletion weight in match mode and stays zero in search
	// mode; every other cell takes the cheapest of its three neighbors.
	function automatic void advance_column(input logic [7:0] text_byte);
		int n;
		int i;
		logic [CELL_W-1:0] above_old;
		logic [CELL_W-1:0] best;
		logic [CELL_W-1:0] cand;
		n = cells_in_use();
		diag_cell = dp_column[0];
		dp_column[0] = search_on ? '0 : capped_sum(dp_column[0], del_weight);
		for (i = 1; i <= n; i++) begin
			above_old = dp_column[i];
			best = capped_sum(diag_cell,
				(pattern_bytes[i-1] == text_byte) ? '0 : sub_weight);
			cand = capped_sum(dp_column[i-1], ins_weight);
			if (cand < best)
				best = cand;
			cand = capped_sum(above_old, del_weight);
			if (cand < best)
				best = cand;
			diag_cell = above_old;
			dp_column[i] = best;
		end
		if (dp_column[n] < best_bottom)
			best_bottom = dp_column[n];
	endfunction

	// Applies one accepted item and queues the distance it produces, if any.
	// An end item with no string open reports the empty-text result.
	function automatic void score_item(input engine_item_t it);
		case (it.func) inside
			FUNC_LOAD: begin
				pattern_bytes[it.position] = it.char_value;
			end
			FUNC_TEXT, FUNC_END: begin
				if (!string_open)
					open_text();
				if (it.func == FUNC_TEXT)
					advance_column(it.char_value);
				if (it.func == FUNC_END || it.last) begin
					expected_distances.push_back(search_on ? best_bottom :
						dp_column[cells_in_use()]);
					string_open = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver, receiver and checkers
	// ------------------------------------------------------------------

	// The next item is offered once the current one has been taken. Gaps are
	// inserted at random at the rate of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.func <= FUNC_LOAD;
			item_ch.position <= '0;
			item_ch.char_value <= '0;
			item_ch.last <= 1'b0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				next_item = pending_items.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.func <= next_item.func;
				item_ch.position <= next_item.position;
				item_ch.char_value <= next_item.char_value;
				item_ch.last <= next_item.last;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Both checkers sample at the rising edge, so they see the values from
	// before any update made at that edge. The core registers its result, so
	// an item's distance can never be collected at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready)
			score_item({item_ch.func, item_ch.position, item_ch.char_value, item_ch.last});
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_distances.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: distance %0d arrived with none expected", $time,
						result_ch.distance);
			end else begin
				wanted_distance = expected_distances.pop_front();
				if (result_ch.distance !== wanted_distance) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: distance mismatch, expected %0d (0x%08h) got %0d (0x%08h)",
							$time, wanted_distance, wanted_distance,
							result_ch.distance, result_ch.distance);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Register write over the APB port: setup cycle, then access cycle. The
	// predictor copy follows, and any open string is dropped as in the core.
	// Bits above a register's width carry noise.
	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		logic [31:0] field_mask;
		field_mask = (index == REG_MODE) ? 32'h1 : (index == REG_LEN) ? 32'h7F : 32'hFFFF;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= (value & field_mask) | ($urandom() & ~field_mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_SUB: sub_weight = value[WGT_W-1:0];
			REG_DEL: del_weight = value[WGT_W-1:0];
			REG_INS: ins_weight = value[WGT_W-1:0];
			REG_LEN: length_reg = value[PLEN_W-1:0];
			REG_MODE: search_on = value[0];
			default: begin
			end
		endcase
		string_open = 1'b0;
	endtask

	function automatic void push_item(input logic [1:0] func, input logic [5:0] position,
		input logic [7:0] char_value, input logic last);
		engine_item_t it;
		it.func = func;
		it.position = position;
		it.char_value = char_value;
		it.last = last;
		pending_items.push_back(it);
		if (func == FUNC_LOAD)
			loaded_mask[position] = 1'b1;
		if (func != FUNC_UNUSED)
			random_count++;
	endfunction

	// Mostly a four-letter alphabet so that matches are common.
	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 3) != 0)
			return 8'h61 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void fill_pattern(input int len);
		int p;
		for (p = 0; p < len && p < PATTERN_MAX; p++)
			if (!loaded_mask[p])
				push_item(FUNC_LOAD, 6'(p), pick_char(), 1'($urandom_range(0, 1)));
	endfunction

	// A well-formed text string: a few bytes closed either by last on the
	// final byte or by an end item. Now and then a pattern byte is rewritten
	// in the middle of the string. An empty string is a lone end item.
	function automatic void queue_string();
		int bytes;
		int k;
		logic close_by_end;
		bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
		close_by_end = (bytes == 0) || ($urandom_range(0, 3) == 0);
		for (k = 0; k < bytes; k++) begin
			if ($urandom_range(0, 19) == 0)
				push_item(FUNC_LOAD, 6'($urandom_range(0, 63)), pick_char(),
					1'($urandom_range(0, 1)));
			push_item(FUNC_TEXT, 6'($urandom_range(0, 63)), pick_char(),
				!close_by_end && k == bytes - 1);
		end
		if (close_by_end)
			push_item(FUNC_END, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_ch.valid || expected_distances.size() != 0)
			@(negedge clk);
	endtask

	// Registers may only change with the core idle; a text item without last
	// may still be walking its column after the last distance came out.
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes every register, the mode at random. Kind 1 takes the top of each other
	// range, kind 2 the bottom, anything else random values with extremes mixed in.
	task automatic program_settings(input int kind);
		logic [31:0] w [3];
		logic [31:0] len;
		int j;
		for (j = 0; j < 3; j++) begin
			case ($urandom_range(0, 7))
				0: w[j] = 32'd0;
				1: w[j] = 32'hFFFF;
				2: w[j] = 32'd256;
				default: w[j] = 32'($urandom_range(0, 65535));
			endcase
			if (kind == 1)
				w[j] = 32'hFFFF;
			else if (kind == 2)
				w[j] = 32'd0;
		end
		if (kind == 1)
			len = 32'd127;
		else if (kind == 2)
			len = 32'd0;
		else if ($urandom_range(0, 99) < 85)
			len = 32'($urandom_range(0, 12));
		else if ($urandom_range(0, 2) == 0)
			len = PATTERN_MAX;
		else
			len = 32'($urandom_range(13, 127));
		write_reg(REG_SUB, w[0]);
		write_reg(REG_DEL, w[1]);
		write_reg(REG_INS, w[2]);
		write_reg(REG_LEN, len);
		write_reg(REG_MODE, 32'($urandom_range(0, 1)));
		fill_pattern(int'(len));
	endtask

	// Mostly well-formed strings, with ignored items, lone text bytes with a
	// random last flag, and the odd pause until everything has come back.
	task automatic random_step();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			queue_string();
		else if (pick < 88)
			push_item(FUNC_UNUSED, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		else if (pick < 96)
			push_item(FUNC_TEXT, 6'($urandom_range(0, 63)), pick_char(),
				1'($urandom_range(0, 1)));
		else
			wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int phase;
		int target;
		int stop_at;
		int waited;
		logic first_setting;

		// The reset value is applied by a nonblocking update so that the
		// clocked blocks, already waiting, see its falling edge at time zero.
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sub_weight = 16'd256;
		del_weight = 16'd256;
		ins_weight = 16'd256;
		length_reg = '0;
		search_on = 1'b0;
		string_open = 1'b0;
		loaded_mask = '0;
		random_count = 0;
		sender_idle_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling. A four-byte pattern with both byte
		// extremes in it.
		write_reg(REG_LEN, 32'd4);
		push_item(FUNC_LOAD, 6'd0, 8'h00, 1'b0);
		push_item(FUNC_LOAD, 6'd1, 8'hFF, 1'b0);
		push_item(FUNC_LOAD, 6'd2, "a", 1'b0);
		push_item(FUNC_LOAD, 6'd63, "b", 1'b1);
		push_item(FUNC_LOAD, 6'd3, "b", 1'b0);
		// End of text with no string open gives the empty-text distance.
		push_item(FUNC_END, 6'd63, 8'hFF, 1'b1);
		// The unused function code must be ignored.
		push_item(FUNC_UNUSED, 6'd21, 8'h5A, 1'b1);
		// Exact match of the whole pattern.
		push_item(FUNC_TEXT, 6'd0, 8'h00, 1'b0);
		push_item(FUNC_TEXT, 6'd63, 8'hFF, 1'b0);
		push_item(FUNC_TEXT, 6'd0, "a", 1'b0);
		push_item(FUNC_TEXT, 6'd0, "b", 1'b1);
		// Pattern rewrite in the middle of a string, closed by an end item.
		push_item(FUNC_TEXT, 6'd0, "a", 1'b0);
		push_item(FUNC_LOAD, 6'd0, "a", 1'b0);
		push_item(FUNC_TEXT, 6'd0, "x", 1'b0);
		push_item(FUNC_END, 6'd0, 8'h00, 1'b0);
		// A string left open is dropped by the next register write.
		push_item(FUNC_TEXT, 6'd0, "z", 1'b0);
		wait_idle();
		write_reg(REG_MODE, 32'd1);
		push_item(FUNC_TEXT, 6'd0, "a", 1'b0);
		push_item(FUNC_TEXT, 6'd0, "b", 1'b1);
		wait_idle();
		// Free substitution against the most expensive steps.
		write_reg(REG_SUB, 32'd0);
		write_reg(REG_DEL, 32'hFFFF);
		write_reg(REG_INS, 32'hFFFF);
		push_item(FUNC_TEXT, 6'd0, "a", 1'b0);
		push_item(FUNC_TEXT, 6'd0, "q", 1'b1);
		wait_idle();
		// Empty pattern, in both closing styles.
		write_reg(REG_LEN, 32'd0);
		push_item(FUNC_END, 6'd0, 8'h00, 1'b0);
		push_item(FUNC_TEXT, 6'd0, "c", 1'b1);

		// Random part in four idling phases, several register settings in
		// each. The first setting of the first two phases takes the extremes.
		random_count = 0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 84;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 84;
				end
				default: begin
					sender_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			target = (phase + 1) * RANDOM_ITEMS / 4;
			first_setting = 1'b1;
			while (random_count < target) begin
				wait_idle();
				program_settings(first_setting && phase < 2 ? phase + 1 : 0);
				first_setting = 1'b0;
				stop_at = random_count + $urandom_range(20, 45);
				while (random_count < stop_at && random_count < target)
					random_step();
			end
		end

		// Let everything come back, then allow for work still in flight.
		for (waited = 0; waited < DRAIN_LIMIT && (pending_items.size() != 0 ||
			item_ch.valid || expected_distances.size() != 0); waited++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_distances.size() != 0)
			$display("%0d expected distances never arrived", expected_distances.size());
		if (error_count == 0 && expected_distances.size() == 0 && pending_items.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
